>>> sv/rpwe_pkg.sv
// Shared types and constants for the remote pulse-width encoder.
// No dependencies; every other file but rpwe_out_if refers to it by scoped names.
package rpwe_pkg;

  localparam int CODE_W    = 24;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int BIT_W     = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS    = 1'd1;

  // Input word actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Register reset values
  localparam logic [DATA_W-1:0] REPEAT_RESET = 8'd50;
  localparam logic [DATA_W-1:0] GAP_RESET    = 8'd20;

  // Frame lengths in bits
  localparam logic [BIT_W-1:0] LONG_BITS  = 5'd24;
  localparam logic [BIT_W-1:0] SHORT_BITS = 5'd12;

  // Queued code: mode flag above the code bits
  typedef struct packed {
    logic              short_mode;
    logic [CODE_W-1:0] code_bits;
  } code_word_t;

  // Queue status towards the sequencer
  typedef struct packed {
    logic       not_empty;
    logic       full;
    code_word_t head_word;
  } q_stat_t;

  // Sequencer status for one tick
  typedef struct packed {
    logic pop;
    logic level;
    logic active_nxt;
  } seq_stat_t;

endpackage

>>> sv/rpwe_in_if.sv
// Input channel of the encoder: valid/ready handshake and one input word.
// Depends on rpwe_pkg for field widths.
interface rpwe_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [rpwe_pkg::CODE_W-1:0]  code_bits;
  logic                         short_mode;

  modport source (output valid, action, code_bits, short_mode, input ready);
  modport sink   (input valid, action, code_bits, short_mode, output ready);
endinterface

>>> sv/rpwe_out_if.sv
// Result channel of the encoder: valid/ready handshake and one result word.
// No package dependencies.
interface rpwe_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic accepted;
  logic busy_res;

  modport source (output valid, line_level, accepted, busy_res, input ready);
  modport sink   (input valid, line_level, accepted, busy_res, output ready);
endinterface

>>> sv/rpwe_queue.sv
// Code queue: circular buffer in a memory with a registered head read.
// Depends on rpwe_pkg (code_word_t, q_stat_t).
module rpwe_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rpwe_pkg::code_word_t wdata,
  input  logic                 pop,
  output logic                 push_ok,
  output logic                 pend_nxt,
  output rpwe_pkg::q_stat_t    q_st
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = ((AW > CW) ? AW : CW) + 1;

  rpwe_pkg::code_word_t mem [QUEUE_DEPTH];
  rpwe_pkg::code_word_t rd_data_r;
  rpwe_pkg::code_word_t byp_data_r;
  logic                 byp_r, byp_nxt;
  logic [AW-1:0]        head_r, head_nxt, head_inc, tail, rd_addr;
  logic [CW-1:0]        count_r, count_nxt;
  logic [SW-1:0]        tail_sum;
  logic                 full;

  // Pointer arithmetic with wrap at the queue depth
  always_comb begin
    full     = (count_r == CW'(QUEUE_DEPTH));
    push_ok  = push && !full;
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= SW'(QUEUE_DEPTH)) begin
      tail = AW'(tail_sum - SW'(QUEUE_DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
    head_inc  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
    head_nxt  = pop ? head_inc : head_r;
    rd_addr   = head_nxt;
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop) begin
      count_nxt = count_r - CW'(1);
    end
    pend_nxt = (count_nxt != '0);
    // a word written into an empty queue is the next head: forward it
    byp_nxt  = push_ok && (count_r == '0);
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
    if (byp_nxt) begin
      byp_data_r <= wdata;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      byp_r   <= byp_nxt;
    end
  end

  assign q_st.not_empty = (count_r != '0);
  assign q_st.full      = full;
  assign q_st.head_word = byp_r ? byp_data_r : rd_data_r;

endmodule

>>> sv/rpwe_seq.sv
// Frame sequencer: phase, bit and tick counters, one step per tick word.
// Depends on rpwe_pkg (code_word_t, q_stat_t, seq_stat_t, constants).
module rpwe_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              tick,
  input  rpwe_pkg::q_stat_t                 q_st,
  input  logic [rpwe_pkg::DATA_W-1:0]       repeat_count,
  input  logic [rpwe_pkg::DATA_W-1:0]       gap_ticks,
  output rpwe_pkg::seq_stat_t               st
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_BITA, PH_BITB, PH_STOP, PH_GAP
  } phase_t;

  phase_t                          phase_r, ph0, phase_nxt;
  rpwe_pkg::code_word_t            code_r, code0;
  logic [rpwe_pkg::BIT_W-1:0]      bit_r, bi0, bit_nxt, bi_inc, nbits;
  logic [rpwe_pkg::DATA_W-1:0]     tick_r, tl0, tl1, tick_nxt;
  logic [rpwe_pkg::DATA_W-1:0]     rep_r, rl0, rl1, rep_nxt;
  logic [rpwe_pkg::DATA_W-1:0]     gap_len;
  logic                            take, level;

  // Length of the first half of a bit: two ticks when the bit and the mode differ
  function automatic logic [rpwe_pkg::DATA_W-1:0] first_len(
    rpwe_pkg::code_word_t c, logic [rpwe_pkg::BIT_W-1:0] bi);
    logic b;
    b = c.code_bits[5'd23 - bi];
    return (b ^ c.short_mode) ? 8'd2 : 8'd1;
  endfunction

  always_comb begin
    // take a waiting code on a tick while idle and start its frame
    take = tick && (phase_r == PH_IDLE) && q_st.not_empty;
    ph0  = phase_r;
    code0 = code_r;
    bi0  = bit_r;
    tl0  = tick_r;
    rl0  = rep_r;
    if (take) begin
      code0 = q_st.head_word;
      rl0   = (repeat_count == '0) ? 8'd1 : repeat_count;
      bi0   = '0;
      if (q_st.head_word.short_mode) begin
        ph0 = PH_LEAD;
        tl0 = 8'd1;
      end else begin
        ph0 = PH_BITA;
        tl0 = first_len(q_st.head_word, '0);
      end
    end

    gap_len   = (gap_ticks == '0) ? 8'd1 : gap_ticks;
    nbits     = code0.short_mode ? rpwe_pkg::SHORT_BITS : rpwe_pkg::LONG_BITS;
    bi_inc    = bi0 + 5'd1;
    tl1       = (tl0 != '0) ? tl0 - 8'd1 : '0;
    rl1       = (rl0 != '0) ? rl0 - 8'd1 : '0;
    phase_nxt = ph0;
    bit_nxt   = bi0;
    tick_nxt  = tl0;
    rep_nxt   = rl0;
    level     = 1'b0;

    if (tick && (ph0 != PH_IDLE)) begin
      // line level for this tick
      case (ph0)
        PH_LEAD: level = 1'b1;
        PH_BITA: level = !code0.short_mode;
        PH_BITB: level = code0.short_mode;
        PH_STOP: level = 1'b1;
        default: level = 1'b0;
      endcase

      // step to the next phase when the current one runs out
      tick_nxt = tl1;
      if (tl1 == '0) begin
        unique case (ph0)
          PH_LEAD: begin
            bit_nxt   = '0;
            phase_nxt = PH_BITA;
            tick_nxt  = first_len(code0, '0);
          end
          PH_BITA: begin
            phase_nxt = PH_BITB;
            tick_nxt  = 8'd3 - first_len(code0, bi0);
          end
          PH_BITB: begin
            bit_nxt = bi_inc;
            if (bi_inc >= nbits) begin
              if (code0.short_mode) begin
                phase_nxt = PH_GAP;
                tick_nxt  = gap_len;
              end else begin
                phase_nxt = PH_STOP;
                tick_nxt  = 8'd1;
              end
            end else begin
              phase_nxt = PH_BITA;
              tick_nxt  = first_len(code0, bi_inc);
            end
          end
          PH_STOP: begin
            phase_nxt = PH_GAP;
            tick_nxt  = gap_len;
          end
          default: begin
            // end of gap: repeat the frame or fall idle
            rep_nxt = rl1;
            if (rl1 != '0) begin
              bit_nxt = '0;
              if (code0.short_mode) begin
                phase_nxt = PH_LEAD;
                tick_nxt  = 8'd1;
              end else begin
                phase_nxt = PH_BITA;
                tick_nxt  = first_len(code0, '0);
              end
            end else begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
            end
          end
        endcase
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      code_r  <= '0;
      bit_r   <= '0;
      tick_r  <= '0;
      rep_r   <= '0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      code_r  <= code0;
      bit_r   <= bit_nxt;
      tick_r  <= tick_nxt;
      rep_r   <= rep_nxt;
    end
  end

  assign st.pop        = take;
  assign st.level      = level;
  assign st.active_nxt = (phase_nxt != PH_IDLE);

endmodule

>>> sv/remote_pulse_width_encoder.sv
// The input word is taken into the input register; its result word is then registered in the result register.
// Throughput: one word per cycle while the receiver takes results; the input register and the result register
// decouple the two channels, so the input stalls only when both are full and the result is not taken.
// Reset (rst_n, synchronous): queue empty, sequencer idle, repeat count 50,
// gap 20 ticks. Depends on rpwe_pkg, rpwe_in_if, rpwe_out_if, rpwe_queue, rpwe_seq.
module remote_pulse_width_encoder #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rpwe_in_if.sink                            in_ch,
  rpwe_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [rpwe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpwe_pkg::DATA_W-1:0]        cfg_wdata
);

  logic                         s1_valid_r;
  logic                         s1_action_r;
  rpwe_pkg::code_word_t         s1_word_r;
  logic                         adv, tick, load;
  logic                         push_ok, pend_nxt;
  logic                         out_valid_r, level_r, acc_r, busy_r;
  logic [rpwe_pkg::DATA_W-1:0]  repeat_r, gap_r;
  rpwe_pkg::q_stat_t            q_st;
  rpwe_pkg::seq_stat_t          seq_st;

  // Stage handshake
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign tick        = adv && (s1_action_r == rpwe_pkg::ACT_TICK);
  assign load        = adv && (s1_action_r == rpwe_pkg::ACT_LOAD);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action_r          <= in_ch.action;
      s1_word_r.code_bits  <= in_ch.code_bits;
      s1_word_r.short_mode <= in_ch.short_mode;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r <= rpwe_pkg::REPEAT_RESET;
      gap_r    <= rpwe_pkg::GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpwe_pkg::CFG_REPEAT_COUNT: repeat_r <= cfg_wdata;
        rpwe_pkg::CFG_GAP_TICKS:    gap_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rpwe_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (load),
    .wdata    (s1_word_r),
    .pop      (seq_st.pop),
    .push_ok  (push_ok),
    .pend_nxt (pend_nxt),
    .q_st     (q_st)
  );

  rpwe_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick         (tick),
    .q_st         (q_st),
    .repeat_count (repeat_r),
    .gap_ticks    (gap_r),
    .st           (seq_st)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      level_r <= seq_st.level;
      acc_r   <= push_ok;
      busy_r  <= seq_st.active_nxt || pend_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_level = level_r;
  assign out_ch.accepted   = acc_r;
  assign out_ch.busy_res   = busy_r;

  // A code is only taken from a queue that holds one
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    seq_st.pop |-> q_st.not_empty)
    else $error("code taken from an empty queue");

  // A load and a take never fall in the same cycle
  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    seq_st.pop |-> !push_ok)
    else $error("queue written and read out in one cycle");

  // A word that leaves the encoder idle never drives the line high
  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !busy_r) |-> !level_r)
    else $error("line high on a word that ends idle");

  // A refused load only happens with a full queue
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !push_ok) |-> q_st.full)
    else $error("load refused with room in the queue");

endmodule

>>> sim/remote_pulse_width_encoder_test.sv
// Self-checking bench for the remote pulse-width encoder: a line predictor tracks
// queue and sequencer, and every result word is checked in order against it.
// Depends on rpwe_pkg, rpwe_in_if, rpwe_out_if and remote_pulse_width_encoder.
module remote_pulse_width_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 400;
  localparam int TAIL_CYCLES = 8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEAD, ST_MARK, ST_SPACE, ST_STOP, ST_GAP
  } tx_state_t;

  typedef enum int {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_CADENCE} rx_pattern_t;

  typedef struct packed {
    logic level;
    logic accepted;
    logic busy;
  } line_word_t;

  // Line predictor plus the store of line words still due from the block
  class encoder_tracker;
    rpwe_pkg::code_word_t              waiting[$];
    rpwe_pkg::code_word_t              cur;
    logic [rpwe_pkg::BIT_W-1:0]        bit_idx;
    tx_state_t                         state;
    logic [7:0]                        ticks_left;
    logic [7:0]                        reps_left;
    logic [7:0]                        repeat_reg;
    logic [7:0]                        gap_reg;
    line_word_t                        due_words[$];
    int                                errors;

    function new();
      cur        = '0;
      bit_idx    = '0;
      state      = ST_IDLE;
      ticks_left = '0;
      reps_left  = '0;
      repeat_reg = rpwe_pkg::REPEAT_RESET;
      gap_reg    = rpwe_pkg::GAP_RESET;
      errors     = 0;
    endfunction

    function void set_register(logic [rpwe_pkg::CFG_IDX_W-1:0] idx,
                               logic [rpwe_pkg::DATA_W-1:0] val);
      case (idx)
        rpwe_pkg::CFG_REPEAT_COUNT: repeat_reg = val;
        rpwe_pkg::CFG_GAP_TICKS:    gap_reg = val;
        default: ;
      endcase
    endfunction

    function bit busy();
      return (state != ST_IDLE) || (waiting.size() != 0);
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function logic cur_bit();
      return cur.code_bits[rpwe_pkg::CODE_W - 1 - int'(bit_idx)];
    endfunction

    // first half of a bit; short frames swap the polarity
    function logic [7:0] mark_len();
      if (cur.short_mode) return cur_bit() ? 8'd1 : 8'd2;
      return cur_bit() ? 8'd2 : 8'd1;
    endfunction

    function void start_bit();
      state      = ST_MARK;
      ticks_left = mark_len();
    endfunction

    // a zero gap still lasts one tick
    function void start_gap();
      state      = ST_GAP;
      ticks_left = (gap_reg == 0) ? 8'd1 : gap_reg;
    endfunction

    function void start_frame();
      bit_idx = '0;
      if (cur.short_mode) begin
        state      = ST_LEAD;
        ticks_left = 8'd1;
      end else begin
        start_bit();
      end
    endfunction

    function logic level_now();
      case (state)
        ST_LEAD:  return 1'b1;
        ST_MARK:  return !cur.short_mode;
        ST_SPACE: return cur.short_mode;
        ST_STOP:  return 1'b1;
        default:  return 1'b0;
      endcase
    endfunction

    function void advance_tick();
      logic [rpwe_pkg::BIT_W-1:0] nbits;
      nbits = cur.short_mode ? rpwe_pkg::SHORT_BITS : rpwe_pkg::LONG_BITS;
      if (ticks_left != 0) ticks_left--;
      if (ticks_left != 0) return;
      case (state)
        ST_LEAD: begin
          bit_idx = '0;
          start_bit();
        end
        ST_MARK: begin
          state      = ST_SPACE;
          ticks_left = 8'd3 - mark_len();
        end
        ST_SPACE: begin
          bit_idx++;
          if (bit_idx >= nbits) begin
            if (cur.short_mode) begin
              start_gap();
            end else begin
              state      = ST_STOP;
              ticks_left = 8'd1;
            end
          end else begin
            start_bit();
          end
        end
        ST_STOP: start_gap();
        default: begin
          // end of gap: repeat the frame or fall idle
          if (reps_left != 0) reps_left--;
          if (reps_left != 0) begin
            start_frame();
          end else begin
            state      = ST_IDLE;
            ticks_left = '0;
          end
        end
      endcase
    endfunction

    function line_word_t predict_word(logic act, logic [rpwe_pkg::CODE_W-1:0] code, logic sh);
      line_word_t r;
      r = '0;
      if (act == rpwe_pkg::ACT_LOAD) begin
        if (waiting.size() < QUEUE_DEPTH) begin
          waiting.push_back({sh, code});
          r.accepted = 1'b1;
        end
      end else begin
        // an idle tick takes a waiting code and starts on this same tick
        if (state == ST_IDLE && waiting.size() != 0) begin
          cur       = waiting.pop_front();
          reps_left = (repeat_reg == 0) ? 8'd1 : repeat_reg;
          start_frame();
        end
        if (state != ST_IDLE) begin
          r.level = level_now();
          advance_tick();
        end
      end
      r.busy = busy();
      return r;
    endfunction

    function void note_word(logic act, logic [rpwe_pkg::CODE_W-1:0] code, logic sh);
      due_words.push_back(predict_word(act, code, sh));
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
      end
    endfunction

    function void check_word(line_word_t got);
      line_word_t want;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual %b", $time, got);
        return;
      end
      want = due_words.pop_front();
      compare_field("line_level", want.level, got.level);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("busy_res", want.busy, got.busy);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we;
  logic [rpwe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rpwe_pkg::DATA_W-1:0]    cfg_wdata;
  int                             results_seen = 0;
  int                             stall_count = 0;
  int                             burst_left = 0;
  encoder_tracker                 tracker = new();

  rpwe_in_if  in_bus();
  rpwe_out_if out_bus();

  remote_pulse_width_encoder #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one word in bursts with random gaps; returns once it is taken
  task automatic send_word(input logic act, input logic [rpwe_pkg::CODE_W-1:0] code,
                           input logic sh);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(99) < 30) ? 0 : $urandom_range(6, 1);
      burst_left = $urandom_range(24, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid      = 1'b1;
    in_bus.action     = act;
    in_bus.code_bits  = code;
    in_bus.short_mode = sh;
    do @(posedge clk); while (!in_bus.ready);
    tracker.note_word(act, code, sh);
  endtask

  // Drop valid and wait for every due word to come back
  task automatic settle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rpwe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpwe_pkg::DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_register(idx, val);
  endtask

  // One setting: mostly ticks, loads at the given rate, capped in number
  task automatic run_phase(input logic [7:0] reps, input logic [7:0] gap, input int n_words,
                           input int load_pct, input int load_cap);
    int loads;
    logic [rpwe_pkg::CODE_W-1:0] code;
    write_reg(rpwe_pkg::CFG_REPEAT_COUNT, reps);
    write_reg(rpwe_pkg::CFG_GAP_TICKS, gap);
    loads = 0;
    for (int i = 0; i < n_words; i++) begin
      case ($urandom_range(7))
        0:       code = '0;
        1:       code = '1;
        default: code = (rpwe_pkg::CODE_W)'($urandom);
      endcase
      if (loads < load_cap && $urandom_range(99) < load_pct) begin
        send_word(rpwe_pkg::ACT_LOAD, code, 1'($urandom_range(1)));
        loads++;
      end else begin
        send_word(rpwe_pkg::ACT_TICK, code, 1'($urandom_range(1)));
      end
    end
    settle();
  endtask

  // Stimulus
  initial begin : stimulus
    in_bus.valid      = 1'b0;
    in_bus.action     = rpwe_pkg::ACT_TICK;
    in_bus.code_bits  = '0;
    in_bus.short_mode = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = rpwe_pkg::CFG_REPEAT_COUNT;
    cfg_wdata         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // tick with nothing queued, under the reset settings
    send_word(rpwe_pkg::ACT_TICK, '1, 1'b1);
    settle();

    // zero repeat count and zero gap both behave as one
    write_reg(rpwe_pkg::CFG_REPEAT_COUNT, 8'd0);
    write_reg(rpwe_pkg::CFG_GAP_TICKS, 8'd0);
    send_word(rpwe_pkg::ACT_LOAD, 24'hFFFFFF, 1'b0);
    send_word(rpwe_pkg::ACT_LOAD, 24'h000000, 1'b0);
    send_word(rpwe_pkg::ACT_LOAD, 24'hFFFFFF, 1'b1);
    send_word(rpwe_pkg::ACT_LOAD, 24'h000000, 1'b1);
    send_word(rpwe_pkg::ACT_LOAD, 24'hA5C3F0, 1'b1);
    // fill the queue, then one more load that must be refused
    for (int i = 5; i <= QUEUE_DEPTH; i++)
      send_word(rpwe_pkg::ACT_LOAD, (rpwe_pkg::CODE_W)'($urandom), 1'(i));
    settle();

    // random part over several settings, extremes included
    run_phase(8'd1, 8'd1, 250, 15, 1000);
    run_phase(8'd0, 8'd0, 200, 20, 1000);
    run_phase(8'd2, 8'd255, 150, 4, 1000);
    run_phase(8'd3, 8'd6, 250, 12, 1000);
    run_phase(rpwe_pkg::REPEAT_RESET, rpwe_pkg::GAP_RESET, 80, 50, 1);
    run_phase(8'd255, 8'd1, 80, 50, 1);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("remote_pulse_width_encoder_test: PASS");
    else
      $display("remote_pulse_width_encoder_test: FAIL");
    $finish;
  end

  // Receiver: changing ready patterns, plus one long hold-off to back the block up
  initial begin : result_sink
    rx_pattern_t pattern;
    int          stretch;
    int          beat;
    logic        held;
    out_bus.ready = 1'b0;
    pattern       = RX_STEADY;
    stretch       = 0;
    beat          = 0;
    held          = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held          = 1'b1;
        out_bus.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          pattern = rx_pattern_t'($urandom_range(3));
          stretch = $urandom_range(96, 32);
        end
        stretch--;
        beat++;
        case (pattern)
          RX_STEADY: out_bus.ready = 1'b1;
          RX_MOSTLY: out_bus.ready = ($urandom_range(99) < 70);
          RX_SPARSE: out_bus.ready = ($urandom_range(99) < 30);
          default:   out_bus.ready = (beat % 4 != 0);
        endcase
      end
    end
  end

  // Check each accepted result word
  always @(posedge clk) begin : result_check
    if (rst_n && out_bus.valid && out_bus.ready) begin
      tracker.check_word(line_word_t'({out_bus.line_level, out_bus.accepted, out_bus.busy_res}));
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: too long with no word moving on either side
  always @(posedge clk) begin : watchdog
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("remote_pulse_width_encoder_test: FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

endmodule

>>> sim.f
sv/rpwe_pkg.sv
sv/rpwe_in_if.sv
sv/rpwe_out_if.sv
sv/rpwe_queue.sv
sv/rpwe_seq.sv
sv/remote_pulse_width_encoder.sv
sim/remote_pulse_width_encoder_test.sv
